// ===== rtl/pllq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the pooled linked-list queue unit: sizes, command and status
// codes, node record and the control structs between the sequencer and the scanner.
package pllq_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int LIST_COUNT = 8;

  localparam int NODE_W  = $clog2(POOL_DEPTH);
  localparam int LID_W   = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
  localparam int GRP     = 8;
  localparam int NGRP    = (POOL_DEPTH + GRP - 1) / GRP;
  localparam int GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_W   = NGRP * GRP;

  typedef logic [NODE_W-1:0] node_idx_t;
  typedef logic [LID_W-1:0]  lid_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    CMD_OPEN = 3'd0,
    CMD_PUSH = 3'd1,
    CMD_POP  = 3'd2,
    CMD_PEEK = 3'd3,
    CMD_LEN  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_OPEN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_READ,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [7:0]         kind;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    node_idx_t          link;
  } node_t;

  typedef struct packed {
    logic      set_en;
    node_idx_t set_idx;
    logic      clr_en;
    node_idx_t clr_idx;
  } used_upd_t;

  typedef struct packed {
    logic      done;
    logic      full;
    node_idx_t node;
  } scan_rsp_t;

endpackage

// ===== rtl/pllq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command beats and result beats.
// No dependencies.
interface pllq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [2:0]         list_id;
  logic [7:0]         item_type;
  logic signed [15:0] data_a;
  logic signed [15:0] data_b;

  modport source (output valid, command, list_id, item_type, data_a, data_b,
                  input ready);
  modport sink   (input valid, command, list_id, item_type, data_a, data_b,
                  output ready);
endinterface

interface pllq_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_type;
  logic signed [15:0] out_a;
  logic signed [15:0] out_b;
  logic [6:0]         count;
  logic [1:0]         status;

  modport source (output valid, out_type, out_a, out_b, count, status,
                  input ready);
  modport sink   (input valid, out_type, out_a, out_b, count, status,
                  output ready);
endinterface

// ===== rtl/pllq_node_ram.sv =====
`timescale 1ns / 1ps
// Node pool storage: one write port, one read port with registered read data.
// Depends on pllq_pkg for the node record and pool size.
module pllq_node_ram import pllq_pkg::*; (
  input  logic      clk,
  input  logic      wr_en,
  input  node_idx_t wr_addr,
  input  node_t     wr_data,
  input  logic      rd_en,
  input  node_idx_t rd_addr,
  output node_t     rd_data
);

  node_t mem_r [POOL_DEPTH];
  node_t rd_data_r;

  // Write a pushed node, register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/pllq_free_scan.sv =====
`timescale 1ns / 1ps
// Node used bits and the shared free-node scanner, one group of eight bits per cycle.
// Depends on pllq_pkg for sizes and the update/response structs.
module pllq_free_scan import pllq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  used_upd_t upd,
  output scan_rsp_t rsp
);

  logic [POOL_DEPTH-1:0] used_r;
  logic [PAD_W-1:0]      used_pad;
  logic                  active_r;
  logic [GRP_W-1:0]      grp_r;
  logic [GRP-1:0]        grp_bits;
  logic [2:0]            enc;
  logic                  hit;
  logic                  last_grp;
  logic [GRP_W+2:0]      found_wide;

  // Pad nodes past the pool end as used
  for (genvar i = 0; i < PAD_W; i++) begin : g_pad
    if (i < POOL_DEPTH) begin : g_real
      assign used_pad[i] = used_r[i];
    end else begin : g_fill
      assign used_pad[i] = 1'b1;
    end
  end

  assign grp_bits = used_pad[{grp_r, 3'b000} +: GRP];

  // Find the lowest free bit in the current group
  always_comb begin
    enc = 3'd0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        enc = 3'(i);
      end
    end
  end

  assign hit        = ~&grp_bits;
  assign last_grp   = (grp_r == GRP_W'(NGRP - 1));
  assign found_wide = {grp_r, enc};

  assign rsp.done = active_r && (hit || last_grp);
  assign rsp.full = !hit;
  assign rsp.node = found_wide[NODE_W-1:0];

  // Step through the groups until a free node turns up or the pool ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      grp_r    <= '0;
    end else if (start) begin
      active_r <= 1'b1;
      grp_r    <= '0;
    end else if (rsp.done) begin
      active_r <= 1'b0;
    end else if (active_r) begin
      grp_r <= grp_r + 1'b1;
    end
  end

  // Reserve and release nodes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (upd.set_en) begin
        used_r[upd.set_idx] <= 1'b1;
      end
      if (upd.clr_en) begin
        used_r[upd.clr_idx] <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/pooled_linked_list_queues_unit.sv =====
`timescale 1ns / 1ps
// Pooled linked-list queue unit, top level: command sequencer, list table, result register.
// Depends on pllq_pkg, pllq_if, pllq_node_ram and pllq_free_scan.
//
// Eight FIFO queues share a pool of 64 nodes; each queue ends in an empty sentinel node.
// One command is worked at a time. Length, closed-queue, empty-queue and unknown commands go from
// decode straight to the result state; pop and peek on a queue that holds items first read the
// head node through the single read port of the node memory.
// Open and push go through the free-node scanner, which checks eight used bits per cycle and
// steps through the eight-node groups up to the lowest free node (1 to 8 groups).
// The unit is ready again in the cycle the result is loaded; a result waiting on the output holds
// a finished command back, while the next command can already be taken in. No clearing pass
// after reset.
module pooled_linked_list_queues_unit import pllq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pllq_in_if.sink    in_bus,
  pllq_out_if.source out_bus
);

  seq_state_t state_r, state_nxt;

  // Latched command
  logic [2:0]         cmd_r;
  lid_t               idx_r;
  logic               id_ok_r;
  logic [7:0]         type_r;
  logic signed [15:0] a_r, b_r;
  logic [6:0]         idx_ext;

  // List table
  node_idx_t          head_r [LIST_COUNT];
  node_idx_t          tail_r [LIST_COUNT];
  cnt_t               cnt_r  [LIST_COUNT];
  logic [LIST_COUNT-1:0] open_r;
  logic               lst_wr;
  node_idx_t          head_nxt, tail_nxt;
  cnt_t               cnt_nxt;
  logic               open_set;
  node_idx_t          cur_head, cur_tail;
  cnt_t               cur_cnt;
  logic               cur_open;
  logic [CNT_W+6:0]   cnt_wide;

  // Pending result and output register
  logic [7:0]         res_type_r, res_type_nxt;
  logic signed [15:0] res_a_r, res_a_nxt, res_b_r, res_b_nxt;
  logic [6:0]         res_cnt_r, res_cnt_nxt;
  status_t            res_sts_r, res_sts_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_type_r, out_type_nxt;
  logic signed [15:0] out_a_r, out_a_nxt, out_b_r, out_b_nxt;
  logic [6:0]         out_cnt_r, out_cnt_nxt;
  status_t            out_sts_r, out_sts_nxt;

  // Node memory and scanner hookup
  logic       mem_wr, mem_rd;
  node_t      mem_wdata, mem_rdata;
  logic       scan_start;
  used_upd_t  used_upd;
  scan_rsp_t  scan_rsp;

  pllq_node_ram u_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (cur_tail),
    .wr_data (mem_wdata),
    .rd_en   (mem_rd),
    .rd_addr (cur_head),
    .rd_data (mem_rdata)
  );

  pllq_free_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .upd   (used_upd),
    .rsp   (scan_rsp)
  );

  assign idx_ext  = {4'd0, in_bus.list_id};
  assign cur_head = head_r[idx_r];
  assign cur_tail = tail_r[idx_r];
  assign cur_cnt  = cnt_r[idx_r];
  assign cur_open = id_ok_r && open_r[idx_r];
  assign cnt_wide = {7'd0, cur_cnt};

  assign mem_wdata = '{kind: type_r, word_a: a_r, word_b: b_r, link: scan_rsp.node};

  assign in_bus.ready    = (state_r == S_IDLE);
  assign out_bus.valid   = out_valid_r;
  assign out_bus.out_type = out_type_r;
  assign out_bus.out_a   = out_a_r;
  assign out_bus.out_b   = out_b_r;
  assign out_bus.count   = out_cnt_r;
  assign out_bus.status  = out_sts_r;

  // Sequencer: next state, list updates, memory and scanner control
  always_comb begin
    state_nxt     = state_r;
    res_type_nxt  = res_type_r;
    res_a_nxt     = res_a_r;
    res_b_nxt     = res_b_r;
    res_cnt_nxt   = res_cnt_r;
    res_sts_nxt   = res_sts_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_type_nxt  = out_type_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_cnt_nxt   = out_cnt_r;
    out_sts_nxt   = out_sts_r;
    lst_wr        = 1'b0;
    head_nxt      = cur_head;
    tail_nxt      = cur_tail;
    cnt_nxt       = cur_cnt;
    open_set      = 1'b0;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    scan_start    = 1'b0;
    used_upd      = '{set_en: 1'b0, set_idx: scan_rsp.node, clr_en: 1'b0, clr_idx: cur_head};

    unique case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_type_nxt = '0;
        res_a_nxt    = '0;
        res_b_nxt    = '0;
        res_cnt_nxt  = '0;
        res_sts_nxt  = STS_OK;
        state_nxt    = S_DONE;
        unique case (cmd_r)
          CMD_OPEN: begin
            if (!id_ok_r) begin
              res_sts_nxt = STS_EMPTY;
            end else if (cur_open) begin
              res_sts_nxt = STS_OPEN;
            end else begin
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end
          end
          CMD_PUSH, CMD_POP, CMD_PEEK, CMD_LEN: begin
            if (!cur_open) begin
              res_sts_nxt = STS_EMPTY;
            end else if (cmd_r == CMD_PUSH) begin
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end else if (cmd_r == CMD_LEN) begin
              res_cnt_nxt = cnt_wide[6:0];
            end else if (cur_head == cur_tail) begin
              res_sts_nxt = STS_EMPTY;
            end else begin
              mem_rd    = 1'b1;
              state_nxt = S_READ;
            end
          end
          default: begin
            res_sts_nxt = STS_OK;
          end
        endcase
      end

      S_SCAN: begin
        if (scan_rsp.done) begin
          state_nxt = S_DONE;
          if (scan_rsp.full) begin
            res_sts_nxt = STS_FULL;
          end else begin
            used_upd.set_en = 1'b1;
            lst_wr          = 1'b1;
            tail_nxt        = scan_rsp.node;
            if (cmd_r == CMD_OPEN) begin
              head_nxt = scan_rsp.node;
              cnt_nxt  = '0;
              open_set = 1'b1;
            end else begin
              mem_wr  = 1'b1;
              cnt_nxt = cur_cnt + 1'b1;
            end
          end
        end
      end

      S_READ: begin
        res_type_nxt = mem_rdata.kind;
        res_a_nxt    = mem_rdata.word_a;
        res_b_nxt    = mem_rdata.word_b;
        state_nxt    = S_DONE;
        if (cmd_r == CMD_POP) begin
          // Advance the head and release the old head node
          lst_wr          = 1'b1;
          head_nxt        = mem_rdata.link;
          used_upd.clr_en = 1'b1;
          if (cur_cnt != '0) begin
            cnt_nxt = cur_cnt - 1'b1;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = res_type_r;
          out_a_nxt     = res_a_r;
          out_b_nxt     = res_b_r;
          out_cnt_nxt   = res_cnt_r;
          out_sts_nxt   = res_sts_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      cmd_r   <= in_bus.command;
      idx_r   <= idx_ext[LID_W-1:0];
      id_ok_r <= (idx_ext < 7'(LIST_COUNT));
      type_r  <= in_bus.item_type;
      a_r     <= in_bus.data_a;
      b_r     <= in_bus.data_b;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_type_r <= res_type_nxt;
    res_a_r    <= res_a_nxt;
    res_b_r    <= res_b_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_sts_r  <= res_sts_nxt;
    out_type_r <= out_type_nxt;
    out_a_r    <= out_a_nxt;
    out_b_r    <= out_b_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_sts_r  <= out_sts_nxt;
  end

  // List table: head, tail, item count and open flag per queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (lst_wr) begin
      head_r[idx_r] <= head_nxt;
      tail_r[idx_r] <= tail_nxt;
      cnt_r[idx_r]  <= cnt_nxt;
      if (open_set) begin
        open_r[idx_r] <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pllq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the pooled linked-list queue unit, bound to the top level.
// Depends on pllq_pkg for status codes.
module pllq_checker import pllq_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_type,
  input logic [15:0] out_a,
  input logic [15:0] out_b,
  input logic [6:0] out_count,
  input logic [1:0] out_status
);

  // One command in flight: a taken beat drops ready
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another was in flight");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Failing commands return zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |->
      out_type == 8'd0 && out_a == 16'd0 && out_b == 16'd0 && out_count == 7'd0)
    else $error("payload not zero on failing command");

  // Nothing valid right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind pooled_linked_list_queues_unit pllq_checker u_pllq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_type   (out_bus.out_type),
  .out_a      (out_bus.out_a),
  .out_b      (out_bus.out_b),
  .out_count  (out_bus.count),
  .out_status (out_bus.status)
);
